### design/trc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

  localparam int CW    = 10;            // vertex coordinate width
  localparam int DW    = CW + 1;        // signed coordinate difference
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int EW    = PW + 4;        // edge function accumulator
  localparam int ROW_W = 6;
  localparam int MASK_W = 64;

  typedef logic [CW-1:0]           coord_t;
  typedef logic signed [DW-1:0]    diff_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [EW-1:0]    edge_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [MASK_W-1:0]       mask_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } vtx_t;

  // setup products, one per cycle through the shared multiplier
  typedef enum logic [2:0] {
    MAC_D_POS,
    MAC_D_NEG,
    MAC_E1_POS,
    MAC_E1_NEG,
    MAC_E2_POS,
    MAC_E2_NEG
  } mac_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOX,
    S_MAC,
    S_SCAN,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic    mac_en;
    mac_op_t mac_op;
    logic    step_x;
    logic    next_row;
  } edge_ctl_t;

  typedef struct packed {
    row_t  row_index;
    mask_t coverage_mask;
    logic  row_present;
    logic  last_row;
  } row_res_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    coord_diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic edge_t diff_ext(input diff_t d);
    diff_ext = {{(EW-DW){d[DW-1]}}, d};
  endfunction

  function automatic edge_t prod_ext(input prod_t p);
    prod_ext = {{(EW-PW){p[PW-1]}}, p};
  endfunction

  // edge term lies on the same side as the doubled area, or on the edge
  function automatic logic same_side(input edge_t e, input edge_t d);
    if (!d[EW-1] && (d != '0)) begin
      same_side = !e[EW-1];
    end else begin
      same_side = e[EW-1] || (e == '0);
    end
  endfunction

endpackage

`default_nettype wire

### design/trc_edge_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module trc_edge_unit import trc_pkg::*; #(
  parameter int FRACTION_BITS = 4
) (
  input  wire logic      clk,
  input  wire vtx_t      vtx,
  input  wire coord_t    px0,
  input  wire coord_t    py0,
  input  wire edge_ctl_t ctl,
  output logic           covered
);

  diff_t d_bxax, d_byay, d_cxax, d_cyay, d_cxbx, d_cyby;
  diff_t d_pxax, d_pyay, d_pxbx, d_pyby;
  diff_t op_a, op_b;
  prod_t prod;
  edge_t prod_e;
  edge_t sx1, sx2, sy1, sy2;
  edge_t d_r, e1_r, e2_r, re1_r, re2_r;
  edge_t d_nxt, e1_nxt, e2_nxt, re1_nxt, re2_nxt;
  edge_t e3;

  assign d_bxax = coord_diff(vtx.bx, vtx.ax);
  assign d_byay = coord_diff(vtx.by, vtx.ay);
  assign d_cxax = coord_diff(vtx.cx, vtx.ax);
  assign d_cyay = coord_diff(vtx.cy, vtx.ay);
  assign d_cxbx = coord_diff(vtx.cx, vtx.bx);
  assign d_cyby = coord_diff(vtx.cy, vtx.by);
  assign d_pxax = coord_diff(px0, vtx.ax);
  assign d_pyay = coord_diff(py0, vtx.ay);
  assign d_pxbx = coord_diff(px0, vtx.bx);
  assign d_pyby = coord_diff(py0, vtx.by);

  // per-sample steps: one column right, one row down
  assign sx1 = diff_ext(d_byay) <<< FRACTION_BITS;
  assign sx2 = diff_ext(d_cyby) <<< FRACTION_BITS;
  assign sy1 = diff_ext(d_bxax) <<< FRACTION_BITS;
  assign sy2 = diff_ext(d_cxbx) <<< FRACTION_BITS;

  always_comb begin
    case (ctl.mac_op)
      MAC_D_POS: begin
        op_a = d_cxax;
        op_b = d_byay;
      end
      MAC_D_NEG: begin
        op_a = d_cyay;
        op_b = d_bxax;
      end
      MAC_E1_POS: begin
        op_a = d_pxax;
        op_b = d_byay;
      end
      MAC_E1_NEG: begin
        op_a = d_pyay;
        op_b = d_bxax;
      end
      MAC_E2_POS: begin
        op_a = d_pxbx;
        op_b = d_cyby;
      end
      MAC_E2_NEG: begin
        op_a = d_pyby;
        op_b = d_cxbx;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign prod_e = prod_ext(prod);

  always_comb begin
    d_nxt   = d_r;
    e1_nxt  = e1_r;
    e2_nxt  = e2_r;
    re1_nxt = re1_r;
    re2_nxt = re2_r;
    if (ctl.mac_en) begin
      case (ctl.mac_op)
        MAC_D_POS:  d_nxt = prod_e;
        MAC_D_NEG:  d_nxt = d_r - prod_e;
        MAC_E1_POS: e1_nxt = prod_e;
        MAC_E1_NEG: begin
          e1_nxt  = e1_r - prod_e;
          re1_nxt = e1_r - prod_e;
        end
        MAC_E2_POS: e2_nxt = prod_e;
        MAC_E2_NEG: begin
          e2_nxt  = e2_r - prod_e;
          re2_nxt = e2_r - prod_e;
        end
        default: ;
      endcase
    end else if (ctl.step_x) begin
      e1_nxt = e1_r + sx1;
      e2_nxt = e2_r + sx2;
    end else if (ctl.next_row) begin
      // back to the first box column on the next row
      re1_nxt = re1_r - sy1;
      re2_nxt = re2_r - sy2;
      e1_nxt  = re1_r - sy1;
      e2_nxt  = re2_r - sy2;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    e1_r  <= e1_nxt;
    e2_r  <= e2_nxt;
    re1_r <= re1_nxt;
    re2_r <= re2_nxt;
  end

  assign e3      = d_r - e1_r - e2_r;
  assign covered = (d_r != '0) && same_side(e1_r, d_r) && same_side(e2_r, d_r) &&
                   same_side(e3, d_r);

endmodule

`default_nettype wire

### design/trc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module trc_seq import trc_pkg::*; #(
  parameter int TILE_SIZE     = 64,
  parameter int FRACTION_BITS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire vtx_t in_vtx,
  output vtx_t      vtx,
  output coord_t    px0,
  output coord_t    py0,
  output edge_ctl_t ctl,
  input  wire logic covered,
  output logic      res_valid,
  output row_res_t  res,
  input  wire logic res_ready
);

  seq_state_t state_r, state_nxt;
  vtx_t       vtx_r, vtx_nxt;
  coord_t     px0_r, px0_nxt, py0_r, py0_nxt;
  row_t       xlo_r, xlo_nxt, ylo_r, ylo_nxt;
  row_t       xlast_r, xlast_nxt, ylast_r, ylast_nxt;
  row_t       x_r, x_nxt, y_r, y_nxt;
  mask_t      mask_r, mask_nxt;
  logic       empty_r, empty_nxt;
  mac_op_t    mac_op_r, mac_op_nxt;

  coord_t minx, maxx, miny, maxy;
  coord_t xlo_c, ylo_c, xhi_c, yhi_c, xhi_clip, yhi_clip;
  logic   box_empty;

  always_comb begin
    minx = (vtx_r.ax < vtx_r.bx) ? vtx_r.ax : vtx_r.bx;
    minx = (minx < vtx_r.cx) ? minx : vtx_r.cx;
    maxx = (vtx_r.ax > vtx_r.bx) ? vtx_r.ax : vtx_r.bx;
    maxx = (maxx > vtx_r.cx) ? maxx : vtx_r.cx;
    miny = (vtx_r.ay < vtx_r.by) ? vtx_r.ay : vtx_r.by;
    miny = (miny < vtx_r.cy) ? miny : vtx_r.cy;
    maxy = (vtx_r.ay > vtx_r.by) ? vtx_r.ay : vtx_r.by;
    maxy = (maxy > vtx_r.cy) ? maxy : vtx_r.cy;
  end

  assign xlo_c    = minx >> FRACTION_BITS;
  assign ylo_c    = miny >> FRACTION_BITS;
  assign xhi_c    = maxx >> FRACTION_BITS;
  assign yhi_c    = maxy >> FRACTION_BITS;
  assign xhi_clip = (xhi_c > CW'(TILE_SIZE)) ? CW'(TILE_SIZE) : xhi_c;
  assign yhi_clip = (yhi_c > CW'(TILE_SIZE)) ? CW'(TILE_SIZE) : yhi_c;
  assign box_empty = (xlo_c >= xhi_clip) || (ylo_c >= yhi_clip);

  assign vtx = vtx_r;
  assign px0 = px0_r;
  assign py0 = py0_r;

  always_comb begin
    res.row_index     = empty_r ? '0 : y_r;
    res.coverage_mask = empty_r ? '0 : mask_r;
    res.row_present   = !empty_r;
    res.last_row      = empty_r || (y_r == ylast_r);
  end

  always_comb begin
    state_nxt  = state_r;
    vtx_nxt    = vtx_r;
    px0_nxt    = px0_r;
    py0_nxt    = py0_r;
    xlo_nxt    = xlo_r;
    ylo_nxt    = ylo_r;
    xlast_nxt  = xlast_r;
    ylast_nxt  = ylast_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    mask_nxt   = mask_r;
    empty_nxt  = empty_r;
    mac_op_nxt = mac_op_r;
    ctl        = '{mac_en: 1'b0, mac_op: mac_op_r, step_x: 1'b0, next_row: 1'b0};
    in_stall   = (state_r != S_IDLE);
    res_valid  = (state_r == S_EMIT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          vtx_nxt   = in_vtx;
          state_nxt = S_BOX;
        end
      end
      S_BOX: begin
        px0_nxt    = CW'(xlo_c << FRACTION_BITS);
        py0_nxt    = CW'(ylo_c << FRACTION_BITS);
        xlo_nxt    = xlo_c[ROW_W-1:0];
        ylo_nxt    = ylo_c[ROW_W-1:0];
        xlast_nxt  = ROW_W'(xhi_clip - CW'(1));
        ylast_nxt  = ROW_W'(yhi_clip - CW'(1));
        empty_nxt  = box_empty;
        mac_op_nxt = MAC_D_POS;
        state_nxt  = box_empty ? S_EMIT : S_MAC;
      end
      S_MAC: begin
        ctl.mac_en = 1'b1;
        if (mac_op_r == MAC_E2_NEG) begin
          x_nxt     = xlo_r;
          y_nxt     = ylo_r;
          mask_nxt  = '0;
          state_nxt = S_SCAN;
        end else begin
          mac_op_nxt = mac_op_t'(mac_op_r + 3'd1);
        end
      end
      S_SCAN: begin
        mask_nxt[x_r] = covered;
        if (x_r == xlast_r) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.step_x = 1'b1;
          x_nxt      = x_r + ROW_W'(1);
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          if (res.last_row) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.next_row = 1'b1;
            y_nxt        = y_r + ROW_W'(1);
            x_nxt        = xlo_r;
            mask_nxt     = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r    <= vtx_nxt;
    px0_r    <= px0_nxt;
    py0_r    <= py0_nxt;
    xlo_r    <= xlo_nxt;
    ylo_r    <= ylo_nxt;
    xlast_r  <= xlast_nxt;
    ylast_r  <= ylast_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    mask_r   <= mask_nxt;
    empty_r  <= empty_nxt;
    mac_op_r <= mac_op_nxt;
  end

endmodule

`default_nettype wire

### design/triangle_coverage_rasterizer_unit.sv
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  three vertices, 10-bit Q6.4 x and y each
// out_      output     out_valid/out_stall  row index, 64-bit coverage mask, row present, last
//
// the unit takes no new triangle until the last row of the current one is handed off,
// also when the bounding box is empty
// six setup products go through one multiplier, then one sample per cycle is tested
// by stepping the edge terms; each row then hands off its mask
// reset is synchronous, active low; out_stall holds the row in the output register
// and the sequencer keeps the next row until the register frees
`timescale 1ns / 1ps
`default_nettype none

module triangle_coverage_rasterizer_unit import trc_pkg::*; #(
  parameter int TILE_SIZE     = 64,
  parameter int FRACTION_BITS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CW-1:0]     in_first_x,
  input  wire logic [CW-1:0]     in_first_y,
  input  wire logic [CW-1:0]     in_second_x,
  input  wire logic [CW-1:0]     in_second_y,
  input  wire logic [CW-1:0]     in_third_x,
  input  wire logic [CW-1:0]     in_third_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROW_W-1:0]       out_row_index,
  output logic [MASK_W-1:0]      out_coverage_mask,
  output logic                   out_row_present,
  output logic                   out_last_row
);

  vtx_t      in_vtx, vtx;
  coord_t    px0, py0;
  edge_ctl_t ctl;
  logic      covered;
  logic      res_valid, res_ready;
  row_res_t  res;
  logic      out_valid_r, out_valid_nxt;
  row_res_t  out_res_r;

  assign in_vtx = '{ax: in_first_x,  ay: in_first_y,
                    bx: in_second_x, by: in_second_y,
                    cx: in_third_x,  cy: in_third_y};

  trc_seq #(
    .TILE_SIZE     (TILE_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_vtx    (in_vtx),
    .vtx       (vtx),
    .px0       (px0),
    .py0       (py0),
    .ctl       (ctl),
    .covered   (covered),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  trc_edge_unit #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_edge (
    .clk     (clk),
    .vtx     (vtx),
    .px0     (px0),
    .py0     (py0),
    .ctl     (ctl),
    .covered (covered)
  );

  // output register frees on the same edge its row transfers
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_index     = out_res_r.row_index;
  assign out_coverage_mask = out_res_r.coverage_mask;
  assign out_row_present   = out_res_r.row_present;
  assign out_last_row      = out_res_r.last_row;

  a_busy_after_input : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer ready right after taking a triangle");

  a_empty_row_shape : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_row_present) |-> (out_last_row && (out_coverage_mask == '0)))
    else $error("empty-box result with mask bits or not last");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && out_stall) |=>
      ($stable(out_coverage_mask) && $stable(out_row_index)))
    else $error("waiting row overwritten while stalled");

endmodule

`default_nettype wire
